/* hdl/esc_pkg.sv */
package esc_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_TEMP_CALIB    = 3'd0;
   localparam logic [2:0] REG_PRESS_CALIB_A = 3'd1;
   localparam logic [2:0] REG_PRESS_CALIB_B = 3'd2;
   localparam logic [2:0] REG_PRESS_CALIB_C = 3'd3;
   localparam logic [2:0] REG_HUM_CALIB_A   = 3'd4;
   localparam logic [2:0] REG_HUM_CALIB_B   = 3'd5;

   typedef logic [1:0] qty_type;
   localparam qty_type QTY_TEMP  = 2'd0;
   localparam qty_type QTY_PRESS = 2'd1;
   localparam qty_type QTY_HUM   = 2'd2;

   localparam logic signed [31:0] VAL_MAX = 32'sd524287;
   localparam logic signed [31:0] VAL_MIN = -32'sd524288;

   // ceil(2^32 / 25); exact quotient for dividends below 2^30
   localparam logic signed [31:0] RECIP_25 = 32'sd171798692;

endpackage

/* hdl/environmental_sensor_compensation_core.sv */
// Integer compensation of raw temperature, pressure and humidity readings with
// calibration words held in six 64-bit APB registers at byte addresses 8*i.
// One shared 32x32 multiplier runs under a sequencer, with a radix-2 signed
// divider for the one pressure division; the five divisions by 100 in the
// humidity formula are reciprocal multiplies on the same multiplier. The block
// takes one transaction at a time. A pressure transaction whose divisor is
// zero skips the division and ends with the error flag set, and an unused
// selector goes straight to the output. A finished result waits in the output
// register; while the previous result is still stalled there, the block holds
// and takes nothing new.
module environmental_sensor_compensation_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [19:0]                       req_raw_reading,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_quantity,
   output logic signed [19:0]                rsp_value,
   output logic                              rsp_error,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [esc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [esc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [esc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_T0   = 6'd1;
   localparam logic [5:0] S_T1   = 6'd2;
   localparam logic [5:0] S_T2   = 6'd3;
   localparam logic [5:0] S_T3   = 6'd4;
   localparam logic [5:0] S_T4   = 6'd5;
   localparam logic [5:0] S_TS   = 6'd6;
   localparam logic [5:0] S_P0   = 6'd7;
   localparam logic [5:0] S_P1   = 6'd8;
   localparam logic [5:0] S_P2   = 6'd9;
   localparam logic [5:0] S_P3   = 6'd10;
   localparam logic [5:0] S_P4   = 6'd11;
   localparam logic [5:0] S_P5   = 6'd12;
   localparam logic [5:0] S_P6   = 6'd13;
   localparam logic [5:0] S_P7   = 6'd14;
   localparam logic [5:0] S_P8   = 6'd15;
   localparam logic [5:0] S_P9   = 6'd16;
   localparam logic [5:0] S_P10  = 6'd17;
   localparam logic [5:0] S_P11  = 6'd18;
   localparam logic [5:0] S_P12  = 6'd19;
   localparam logic [5:0] S_P13  = 6'd20;
   localparam logic [5:0] S_P14  = 6'd21;
   localparam logic [5:0] S_P15  = 6'd22;
   localparam logic [5:0] S_P16  = 6'd23;
   localparam logic [5:0] S_H1   = 6'd24;
   localparam logic [5:0] S_H2   = 6'd25;
   localparam logic [5:0] S_H3   = 6'd26;
   localparam logic [5:0] S_H4   = 6'd27;
   localparam logic [5:0] S_H5   = 6'd28;
   localparam logic [5:0] S_H6   = 6'd29;
   localparam logic [5:0] S_H7   = 6'd30;
   localparam logic [5:0] S_H8   = 6'd31;
   localparam logic [5:0] S_H9   = 6'd32;
   localparam logic [5:0] S_H10  = 6'd33;
   localparam logic [5:0] S_H11  = 6'd34;
   localparam logic [5:0] S_H12  = 6'd35;
   localparam logic [5:0] S_DIV  = 6'd36;
   localparam logic [5:0] S_OUT  = 6'd37;
   localparam logic [5:0] S_RCP  = 6'd38;

   logic [39:0] tc_ff, ha_ff;
   logic [55:0] pa_ff;
   logic [47:0] pb_ff;
   logic [23:0] pc_ff, hb_ff;

   logic [5:0]  state_ff, state_in, ret_ff, ret_in;
   logic [1:0]  qty_ff, qty_in;
   logic [19:0] raw_ff, raw_in;
   logic signed [31:0] fine_ff, fine_in;
   logic signed [31:0] r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic signed [31:0] r4_ff, r4_in, r5_ff, r5_in;
   logic signed [31:0] res_ff, res_in;
   logic        err_ff, err_in;

   logic [31:0] dn_ff, dn_in, dd_ff, dd_in, rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_qty_ff, rsp_qty_in;
   logic signed [19:0] rsp_val_ff, rsp_val_in;
   logic        rsp_err_ff, rsp_err_in;

   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic signed [31:0] div_q;

   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      unique case (csr_idx)
         esc_pkg::REG_TEMP_CALIB:    prdata = {24'd0, tc_ff};
         esc_pkg::REG_PRESS_CALIB_A: prdata = {8'd0, pa_ff};
         esc_pkg::REG_PRESS_CALIB_B: prdata = {16'd0, pb_ff};
         esc_pkg::REG_PRESS_CALIB_C: prdata = {40'd0, pc_ff};
         esc_pkg::REG_HUM_CALIB_A:   prdata = {24'd0, ha_ff};
         esc_pkg::REG_HUM_CALIB_B:   prdata = {40'd0, hb_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0;
         pa_ff <= '0;
         pb_ff <= '0;
         pc_ff <= '0;
         ha_ff <= '0;
         hb_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            esc_pkg::REG_TEMP_CALIB:    tc_ff <= pwdata[39:0];
            esc_pkg::REG_PRESS_CALIB_A: pa_ff <= pwdata[55:0];
            esc_pkg::REG_PRESS_CALIB_B: pb_ff <= pwdata[47:0];
            esc_pkg::REG_PRESS_CALIB_C: pc_ff <= pwdata[23:0];
            esc_pkg::REG_HUM_CALIB_A:   ha_ff <= pwdata[39:0];
            esc_pkg::REG_HUM_CALIB_B:   hb_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [31:0] s16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic signed [31:0] s8(input logic [7:0] x);
      return {{24{x[7]}}, x};
   endfunction

   logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
   logic signed [31:0] h1, h2, h3, h4, h5, h6, h7;

   assign t1  = {16'd0, tc_ff[15:0]};
   assign t2  = s16(tc_ff[31:16]);
   assign t3  = s8(tc_ff[39:32]);
   assign p1  = {16'd0, pa_ff[15:0]};
   assign p2  = s16(pa_ff[31:16]);
   assign p3  = s8(pa_ff[39:32]);
   assign p4  = s16(pa_ff[55:40]);
   assign p5  = s16(pb_ff[15:0]);
   assign p6  = s8(pb_ff[23:16]);
   assign p7  = s8(pb_ff[31:24]);
   assign p8  = s16(pb_ff[47:32]);
   assign p9  = s16(pc_ff[15:0]);
   assign p10 = {24'd0, pc_ff[23:16]};
   assign h1  = {20'd0, ha_ff[11:0]};
   assign h2  = {20'd0, ha_ff[23:12]};
   assign h3  = s8(ha_ff[31:24]);
   assign h4  = s8(ha_ff[39:32]);
   assign h5  = s8(hb_ff[7:0]);
   assign h6  = {24'd0, hb_ff[15:8]};
   assign h7  = s8(hb_ff[23:16]);

   assign div_q     = neg_ff ? -$signed(dn_ff) : $signed(dn_ff);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      logic signed [31:0] ma, mb, prod, raw32, raw16, sum;
      logic signed [63:0] full;
      logic        div_go, rcp_go;
      logic signed [31:0] div_a, div_b;
      logic [32:0] trial;

      ma     = '0;
      mb     = '0;
      div_go = 1'b0;
      rcp_go = 1'b0;
      div_a  = '0;
      div_b  = 32'sd100;
      raw32  = {12'd0, raw_ff};
      raw16  = {16'd0, raw_ff[15:0]};
      sum    = '0;
      trial  = '0;

      unique case (state_ff)
         S_T1:    begin ma = r1_ff; mb = t2; end
         S_T2:    begin ma = r1_ff >>> 1; mb = r1_ff >>> 1; end
         S_T3:    begin ma = r3_ff; mb = t3 <<< 4; end
         S_TS:    begin ma = fine_ff; mb = 32'sd5; end
         S_P1:    begin ma = r1_ff >>> 2; mb = r1_ff >>> 2; end
         S_P2:    begin ma = r4_ff >>> 11; mb = p6; end
         S_P3:    begin ma = r1_ff; mb = p5; end
         S_P5:    begin ma = r4_ff >>> 13; mb = p3 <<< 5; end
         S_P6:    begin ma = p2; mb = r1_ff; end
         S_P7:    begin ma = 32'sd32768 + r3_ff; mb = p1; end
         S_P8:    begin ma = (32'sd1048576 - raw32) - (r2_ff >>> 12); mb = 32'sd3125; end
         S_P10:   begin ma = r3_ff >>> 3; mb = r3_ff >>> 3; end
         S_P11:   begin ma = p9; mb = r4_ff >>> 13; end
         S_P12:   begin ma = r3_ff >>> 2; mb = p8; end
         S_P13:   begin ma = r3_ff >>> 8; mb = r3_ff >>> 8; end
         S_P14:   begin ma = r4_ff; mb = r3_ff >>> 8; end
         S_P15:   begin ma = r4_ff; mb = p10; end
         S_H1:    begin ma = r5_ff; mb = h3; end
         S_H2:    begin ma = r5_ff; mb = h4; end
         S_H3:    begin ma = r5_ff; mb = h5; end
         S_H4:    begin ma = r5_ff; mb = div_q; end
         S_H6:    begin ma = h2; mb = r2_ff; end
         S_H7:    begin ma = r1_ff; mb = r2_ff; end
         S_H8:    begin ma = r5_ff; mb = h7; end
         S_H10:   begin ma = r3_ff >>> 14; mb = r3_ff >>> 14; end
         S_H11:   begin ma = r4_ff; mb = r1_ff; end
         S_RCP:   begin ma = $signed({2'b00, dn_ff[31:2]}); mb = esc_pkg::RECIP_25; end
         default: ;
      endcase
      full = ma * mb;
      prod = full[31:0];

      state_in = state_ff;
      ret_in   = ret_ff;
      qty_in   = qty_ff;
      raw_in   = raw_ff;
      fine_in  = fine_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      r3_in    = r3_ff;
      r4_in    = r4_ff;
      r5_in    = r5_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      dn_in    = dn_ff;
      dd_in    = dd_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_qty_in   = rsp_qty_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               qty_in = req_cmd;
               raw_in = req_raw_reading;
               res_in = '0;
               err_in = 1'b0;
               unique case (req_cmd)
                  esc_pkg::QTY_TEMP:  state_in = S_T0;
                  esc_pkg::QTY_PRESS: state_in = S_P0;
                  esc_pkg::QTY_HUM:   state_in = S_TS;
                  default:            state_in = S_OUT;
               endcase
            end
         end
         S_T0: begin
            r1_in    = (raw32 >>> 3) - (t1 <<< 1);
            state_in = S_T1;
         end
         S_T1: begin
            r2_in    = prod >>> 11;
            state_in = S_T2;
         end
         S_T2: begin
            r3_in    = prod >>> 12;
            state_in = S_T3;
         end
         S_T3: begin
            r3_in    = prod >>> 14;
            state_in = S_T4;
         end
         S_T4: begin
            fine_in  = r2_ff + r3_ff;
            state_in = S_TS;
         end
         S_TS: begin
            sum   = prod + 32'sd128;
            r5_in = sum >>> 8;
            res_in = sum >>> 8;
            state_in = (qty_ff == esc_pkg::QTY_TEMP) ? S_OUT : S_H1;
         end
         S_P0: begin
            r1_in    = (fine_ff >>> 1) - 32'sd64000;
            state_in = S_P1;
         end
         S_P1: begin
            r4_in    = prod;
            state_in = S_P2;
         end
         S_P2: begin
            r2_in    = prod >>> 2;
            state_in = S_P3;
         end
         S_P3: begin
            r2_in    = r2_ff + (prod <<< 1);
            state_in = S_P4;
         end
         S_P4: begin
            r2_in    = (r2_ff >>> 2) + (p4 <<< 16);
            state_in = S_P5;
         end
         S_P5: begin
            r3_in    = prod >>> 3;
            state_in = S_P6;
         end
         S_P6: begin
            sum      = r3_ff + (prod >>> 1);
            r3_in    = sum >>> 18;
            state_in = S_P7;
         end
         S_P7: begin
            r1_in    = prod >>> 15;
            state_in = S_P8;
         end
         S_P8: begin
            if (r1_ff == 32'sd0) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               div_go = 1'b1;
               div_a  = prod;
               div_b  = r1_ff;
               ret_in = S_P9;
            end
         end
         S_P9: begin
            r3_in    = div_q <<< 1;
            state_in = S_P10;
         end
         S_P10: begin
            r4_in    = prod;
            state_in = S_P11;
         end
         S_P11: begin
            r1_in    = prod >>> 12;
            state_in = S_P12;
         end
         S_P12: begin
            r2_in    = prod >>> 13;
            state_in = S_P13;
         end
         S_P13: begin
            r4_in    = prod;
            state_in = S_P14;
         end
         S_P14: begin
            r4_in    = prod;
            state_in = S_P15;
         end
         S_P15: begin
            r4_in    = prod >>> 17;
            state_in = S_P16;
         end
         S_P16: begin
            sum      = r1_ff + r2_ff + r4_ff + (p7 <<< 7);
            res_in   = r3_ff + (sum >>> 4);
            state_in = S_OUT;
         end
         S_H1: begin
            rcp_go = 1'b1;
            div_a  = prod;
            ret_in = S_H2;
         end
         S_H2: begin
            r1_in  = raw16 - (h1 <<< 4) - (div_q >>> 1);
            rcp_go = 1'b1;
            div_a  = prod;
            ret_in = S_H3;
         end
         S_H3: begin
            r2_in  = div_q;
            rcp_go = 1'b1;
            div_a  = prod;
            ret_in = S_H4;
         end
         S_H4: begin
            rcp_go = 1'b1;
            div_a  = prod >>> 6;
            ret_in = S_H5;
         end
         S_H5: begin
            r2_in    = r2_ff + div_q + 32'sd16384;
            state_in = S_H6;
         end
         S_H6: begin
            r2_in    = prod >>> 10;
            state_in = S_H7;
         end
         S_H7: begin
            r3_in    = prod;
            state_in = S_H8;
         end
         S_H8: begin
            rcp_go = 1'b1;
            div_a  = prod;
            ret_in = S_H9;
         end
         S_H9: begin
            r4_in    = ((h6 <<< 7) + div_q) >>> 4;
            state_in = S_H10;
         end
         S_H10: begin
            r1_in    = prod >>> 10;
            state_in = S_H11;
         end
         S_H11: begin
            r1_in    = prod >>> 1;
            state_in = S_H12;
         end
         S_H12: begin
            res_in   = (r3_ff + r1_ff) >>> 10;
            state_in = S_OUT;
         end
         S_DIV: begin
            trial = {rem_ff, dn_ff[31]};
            if (trial >= {1'b0, dd_ff}) begin
               trial = trial - {1'b0, dd_ff};
               dn_in = {dn_ff[30:0], 1'b1};
            end else begin
               dn_in = {dn_ff[30:0], 1'b0};
            end
            rem_in = trial[31:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ret_ff;
            end
         end
         S_RCP: begin
            dn_in    = full[63:32];
            state_in = ret_ff;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_qty_in   = qty_ff;
               rsp_err_in   = err_ff;
               if (res_ff > esc_pkg::VAL_MAX) begin
                  rsp_val_in = esc_pkg::VAL_MAX[19:0];
               end else if (res_ff < esc_pkg::VAL_MIN) begin
                  rsp_val_in = esc_pkg::VAL_MIN[19:0];
               end else begin
                  rsp_val_in = res_ff[19:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (div_go) begin
         dn_in    = div_a[31] ? 32'(-div_a) : div_a;
         dd_in    = div_b[31] ? 32'(-div_b) : div_b;
         neg_in   = div_a[31] ^ div_b[31];
         rem_in   = '0;
         cnt_in   = '0;
         state_in = S_DIV;
      end else if (rcp_go) begin
         dn_in    = div_a[31] ? 32'(-div_a) : div_a;
         neg_in   = div_a[31];
         state_in = S_RCP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_ff      <= fine_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      qty_ff     <= qty_in;
      raw_ff     <= raw_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
      r3_ff      <= r3_in;
      r4_ff      <= r4_in;
      r5_ff      <= r5_in;
      res_ff     <= res_in;
      err_ff     <= err_in;
      dn_ff      <= dn_in;
      dd_ff      <= dd_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      rsp_qty_ff <= rsp_qty_in;
      rsp_val_ff <= rsp_val_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quantity = rsp_qty_ff;
   assign rsp_value    = rsp_val_ff;
   assign rsp_error    = rsp_err_ff;

endmodule

/* hdl/esc_checker.sv */
module esc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_quantity,
   input logic [19:0] rsp_value,
   input logic        rsp_error,
   input logic        pready
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_error_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |->
         rsp_quantity == esc_pkg::QTY_PRESS && rsp_value == 20'd0)
      else $error("error flag on a non-pressure or nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result dropped or changed");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind environmental_sensor_compensation_core esc_checker u_esc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_quantity (rsp_quantity),
   .rsp_value    (rsp_value),
   .rsp_error    (rsp_error),
   .pready       (pready)
);
